[rtl/core/tcw_pkg.sv]
// shared types, constants and codes for the text console writer
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

	localparam int DEF_COLUMNS = 80;
	localparam int DEF_ROWS    = 25;

	localparam int OP_W   = 2;
	localparam int CHAR_W = 8;
	localparam int IDX_W  = 11;
	localparam int POS_W  = 11;
	localparam int ATTR_W = 8;
	localparam int CELL_W = 16;

	localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0F20;
	localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h0F;
	localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;

	typedef enum logic [OP_W-1:0] {
		OP_PUT   = 2'd0,
		OP_READ  = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_RDWAIT,
		ST_CLEAR,
		ST_SCROLL,
		ST_DONE
	} seq_state_t;

	// what a put does to the screen store
	typedef struct packed {
		logic wr_en;
		logic wr_blank;
		logic scroll;
	} put_act_t;

	typedef struct packed {
		logic [POS_W-1:0]  cursor_pos;
		logic [CELL_W-1:0] cell_data;
		logic              scrolled;
	} res_t;

endpackage

`default_nettype wire

[rtl/core/tcw_ram.sv]
// generic single-write, single-read synchronous ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

[rtl/core/tcw_cursor.sv]
// cursor registers and the put decision: newline, backspace, printable byte
`timescale 1ns / 1ps
`default_nettype none

module tcw_cursor import tcw_pkg::*; #(
	parameter int COLUMNS = DEF_COLUMNS,
	parameter int ROWS    = DEF_ROWS,
	localparam int ADDR_W = $clog2(COLUMNS * ROWS)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              commit,
	input  wire logic [CHAR_W-1:0] char_code,
	output put_act_t               act,
	output logic      [ADDR_W-1:0] wr_addr,
	output logic      [ADDR_W-1:0] lin_pos
);

	localparam int COL_W = $clog2(COLUMNS);
	localparam int ROW_W = $clog2(ROWS);

	logic [COL_W-1:0] col_q, col_n;
	logic [ROW_W-1:0] row_q, row_n;
	logic             last_col, last_row;

	assign lin_pos  = ADDR_W'(int'(row_q) * COLUMNS + int'(col_q));
	assign last_col = (col_q == COL_W'(COLUMNS - 1));
	assign last_row = (row_q == ROW_W'(ROWS - 1));

	always_comb begin
		col_n   = col_q;
		row_n   = row_q;
		act     = '0;
		wr_addr = lin_pos;
		if (char_code == CH_NEWLINE) begin
			col_n = '0;
			if (last_row) begin
				act.scroll = 1'b1;
			end else begin
				row_n = row_q + ROW_W'(1);
			end
		end else if (char_code == CH_BACKSPACE) begin
			// nothing happens at column zero
			if (col_q != '0) begin
				col_n        = col_q - COL_W'(1);
				act.wr_en    = 1'b1;
				act.wr_blank = 1'b1;
				wr_addr      = lin_pos - ADDR_W'(1);
			end
		end else begin
			act.wr_en = 1'b1;
			if (last_col) begin
				col_n = '0;
				if (last_row) begin
					act.scroll = 1'b1;
				end else begin
					row_n = row_q + ROW_W'(1);
				end
			end else begin
				col_n = col_q + COL_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (commit) begin
			col_q <= col_n;
			row_q <= row_n;
		end
	end

endmodule

`default_nettype wire

[rtl/core/tcw_seq.sv]
// operation sequencer: screen sweeps, scroll copy pass, cell reads and puts
`timescale 1ns / 1ps
`default_nettype none

module tcw_seq import tcw_pkg::*; #(
	parameter int COLUMNS = DEF_COLUMNS,
	parameter int ROWS    = DEF_ROWS,
	localparam int ADDR_W = $clog2(COLUMNS * ROWS)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [OP_W-1:0]   op,
	input  wire logic [CHAR_W-1:0] char_code,
	input  wire logic [IDX_W-1:0]  cell_index,
	input  wire logic [ATTR_W-1:0] attr,
	input  wire put_act_t          cur_act,
	input  wire logic [ADDR_W-1:0] cur_wr_addr,
	input  wire logic [ADDR_W-1:0] cur_lin,
	output logic                   cur_commit,
	output logic      [CHAR_W-1:0] char_q,
	output logic                   mem_we,
	output logic      [ADDR_W-1:0] mem_waddr,
	output logic      [CELL_W-1:0] mem_wdata,
	output logic                   mem_re,
	output logic      [ADDR_W-1:0] mem_raddr,
	input  wire logic [CELL_W-1:0] mem_rdata,
	input  wire logic              res_ready,
	output logic                   res_valid,
	output res_t                   res
);

	localparam int CELL_COUNT = COLUMNS * ROWS;
	localparam int SHIFT_CNT  = CELL_COUNT - COLUMNS;

	seq_state_t state_q, state_n;

	op_t              op_q;
	logic [IDX_W-1:0] idx_q;
	logic [CELL_W-1:0] data_q;
	logic             scr_q;
	logic [ADDR_W-1:0] cnt_q;
	logic             cnt_inc, cnt_last, in_range, copy_phase;

	// scroll write-back stage, in the cycle after its read
	logic              cp_vld_s1;
	logic              cp_blank_s1;
	logic [ADDR_W-1:0] cp_addr_s1;

	logic              dir_we;
	logic [ADDR_W-1:0] dir_waddr;
	logic [CELL_W-1:0] dir_wdata;

	assign cnt_last   = (cnt_q == ADDR_W'(CELL_COUNT - 1));
	assign in_range   = (int'(idx_q) < CELL_COUNT);
	assign copy_phase = (cnt_q < ADDR_W'(SHIFT_CNT));

	always_comb begin
		state_n    = state_q;
		in_stall   = 1'b1;
		cur_commit = 1'b0;
		mem_re     = 1'b0;
		mem_raddr  = cnt_q + ADDR_W'(COLUMNS);
		dir_we     = 1'b0;
		dir_waddr  = cnt_q;
		dir_wdata  = BLANK_CELL;
		cnt_inc    = 1'b0;
		res_valid  = 1'b0;
		case (state_q)
			ST_INIT: begin
				dir_we  = 1'b1;
				cnt_inc = 1'b1;
				if (cnt_last) begin
					state_n = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_n = ST_EXEC;
				end
			end
			ST_EXEC: begin
				case (op_q)
					OP_PUT: begin
						cur_commit = 1'b1;
						dir_we     = cur_act.wr_en;
						dir_waddr  = cur_wr_addr;
						dir_wdata  = cur_act.wr_blank ? BLANK_CELL : {attr, char_q};
						state_n    = cur_act.scroll ? ST_SCROLL : ST_DONE;
					end
					OP_READ: begin
						if (in_range) begin
							mem_re    = 1'b1;
							mem_raddr = ADDR_W'(idx_q);
							state_n   = ST_RDWAIT;
						end else begin
							state_n = ST_DONE;
						end
					end
					OP_CLEAR: begin
						state_n = ST_CLEAR;
					end
					default: begin
						state_n = ST_DONE;
					end
				endcase
			end
			ST_RDWAIT: begin
				state_n = ST_DONE;
			end
			ST_CLEAR: begin
				dir_we  = 1'b1;
				cnt_inc = 1'b1;
				if (cnt_last) begin
					state_n = ST_DONE;
				end
			end
			ST_SCROLL: begin
				mem_re  = copy_phase;
				cnt_inc = 1'b1;
				if (cnt_last) begin
					state_n = ST_DONE;
				end
			end
			ST_DONE: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_n = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_INIT;
			end
		endcase
	end

	// the pending scroll write never meets a direct write
	assign mem_we    = cp_vld_s1 | dir_we;
	assign mem_waddr = cp_vld_s1 ? cp_addr_s1 : dir_waddr;
	assign mem_wdata = cp_vld_s1 ? (cp_blank_s1 ? BLANK_CELL : mem_rdata) : dir_wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_INIT;
			cnt_q     <= '0;
			cp_vld_s1 <= 1'b0;
		end else begin
			state_q   <= state_n;
			cp_vld_s1 <= (state_q == ST_SCROLL);
			if (cnt_inc) begin
				cnt_q <= cnt_last ? '0 : cnt_q + ADDR_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		cp_addr_s1  <= cnt_q;
		cp_blank_s1 <= !copy_phase;
		if (state_q == ST_IDLE && in_valid) begin
			op_q   <= op_t'(op);
			char_q <= char_code;
			idx_q  <= cell_index;
			data_q <= '0;
			scr_q  <= 1'b0;
		end
		if (state_q == ST_EXEC && op_q == OP_PUT) begin
			scr_q <= cur_act.scroll;
		end
		if (state_q == ST_RDWAIT) begin
			data_q <= mem_rdata;
		end
	end

	assign res.cursor_pos = POS_W'(cur_lin);
	assign res.cell_data  = data_q;
	assign res.scrolled   = scr_q;

endmodule

`default_nettype wire

[rtl/core/text_console_writer.sv]
// text console writer top level: attribute register, screen store, result register
//
//  channel   direction  handshake               payload
//  in        receive    in_valid / in_stall     op, char_code, cell_index
//  out       send       out_valid / out_stall   cursor_pos, cell_data, scrolled
//  cfg       receive    cfg_wr_en               cfg_wr_data (text attribute)
//
// a put passes from accept through the execute and done states to the result
// register, an in-range read through execute, read wait and done; a new word
// is taken only in idle; a clear sweeps all COLUMNS*ROWS cells, a scroll
// sweeps them too, copying each row up and blanking the last row
// after reset a clearing pass over the COLUMNS*ROWS cells (2000 by default)
// blanks the screen while in_stall stays high
// one word may wait in the result register while the next one is worked on

`timescale 1ns / 1ps
`default_nettype none

module text_console_writer import tcw_pkg::*; #(
	parameter int COLUMNS = DEF_COLUMNS,
	parameter int ROWS    = DEF_ROWS
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [OP_W-1:0]   op,
	input  wire logic [CHAR_W-1:0] char_code,
	input  wire logic [IDX_W-1:0]  cell_index,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic      [POS_W-1:0]  cursor_pos,
	output logic      [CELL_W-1:0] cell_data,
	output logic                   scrolled,
	input  wire logic              cfg_wr_en,
	input  wire logic [ATTR_W-1:0] cfg_wr_data
);

	localparam int CELL_COUNT = COLUMNS * ROWS;
	localparam int ADDR_W     = $clog2(CELL_COUNT);

	logic [ATTR_W-1:0] attr_q;
	put_act_t          cur_act;
	logic [ADDR_W-1:0] cur_wr_addr, cur_lin;
	logic              cur_commit;
	logic [CHAR_W-1:0] char_q;
	logic              mem_we, mem_re;
	logic [ADDR_W-1:0] mem_waddr, mem_raddr;
	logic [CELL_W-1:0] mem_wdata, mem_rdata;
	logic              res_ready, res_valid;
	res_t              res, out_res_q;
	logic              out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= ATTR_RESET;
		end else if (cfg_wr_en) begin
			attr_q <= cfg_wr_data;
		end
	end

	tcw_cursor #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_cursor (
		.clk       (clk),
		.arst_n    (arst_n),
		.commit    (cur_commit),
		.char_code (char_q),
		.act       (cur_act),
		.wr_addr   (cur_wr_addr),
		.lin_pos   (cur_lin)
	);

	tcw_ram #(
		.WIDTH (CELL_W),
		.DEPTH (CELL_COUNT)
	) u_screen (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_addr (mem_waddr),
		.wr_data (mem_wdata),
		.rd_en   (mem_re),
		.rd_addr (mem_raddr),
		.rd_data (mem_rdata)
	);

	tcw_seq #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.op          (op),
		.char_code   (char_code),
		.cell_index  (cell_index),
		.attr        (attr_q),
		.cur_act     (cur_act),
		.cur_wr_addr (cur_wr_addr),
		.cur_lin     (cur_lin),
		.cur_commit  (cur_commit),
		.char_q      (char_q),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_wdata   (mem_wdata),
		.mem_re      (mem_re),
		.mem_raddr   (mem_raddr),
		.mem_rdata   (mem_rdata),
		.res_ready   (res_ready),
		.res_valid   (res_valid),
		.res         (res)
	);

	// result register: takes a new word when empty or being drained
	assign res_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_res_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign cursor_pos = out_res_q.cursor_pos;
	assign cell_data  = out_res_q.cell_data;
	assign scrolled   = out_res_q.scrolled;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken again before the word was worked on");

	a_scroll_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && scrolled |-> cursor_pos == POS_W'((ROWS - 1) * COLUMNS))
		else $error("scroll did not leave the cursor at the start of the last row");

	a_cursor_on_screen: assert property (@(posedge clk) disable iff (!arst_n)
		int'(cur_lin) < CELL_COUNT)
		else $error("cursor left the screen");

endmodule

`default_nettype wire
